// ----- src/ihp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the indexed min-heap unit: default sizes, value width
// and operation codes. No dependencies.
package ihp_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int HANDLES_DEF  = 1024;
  localparam int VAL_W        = 32;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DEL_MIN = 2'd1;
  localparam logic [1:0] OP_DEL_HND = 2'd2;
  localparam logic [1:0] OP_CHANGE  = 2'd3;

endpackage

// ----- src/ihp_ram.sv -----
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two registered read ports.
// Standalone, no package dependency.
module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ----- src/indexed_min_heap_unit.sv -----
`timescale 1ns / 1ps
// Indexed binary min-heap: sequencer over a position store and a handle store.
// Depends on ihp_pkg and ihp_ram.
//
// One operation runs at a time. busy stays high until the cycle in which the
// result is out, and the next start can be taken in that cycle. An accepted
// insert, delete or change walks the heap levels during sift up or sift down
// (each level is one read of the position store and one compare/write-back).
// A rejected operation skips the sift steps. The result appears on the output
// ports for exactly one cycle with done high; it cannot be held off, so capture
// it on that cycle. No clearing pass is needed after reset.
module indexed_min_heap_unit #(
  parameter int CAPACITY = ihp_pkg::CAPACITY_DEF,
  parameter int HANDLES  = ihp_pkg::HANDLES_DEF,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int HW       = $clog2(HANDLES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [HW-1:0]                  handle,
  input  logic signed [ihp_pkg::VAL_W-1:0] value,
  output logic                           done,
  output logic signed [ihp_pkg::VAL_W-1:0] min_value,
  output logic                           heap_empty,
  output logic [HW-1:0]                  new_handle,
  output logic                           error,
  output logic [CW-1:0]                  entry_count
);

  localparam int VW  = ihp_pkg::VAL_W;
  localparam int EW  = VW + HW;
  localparam int NHW = $clog2(HANDLES + 2);
  localparam int SW  = 4;

  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_RDM   = 4'd1;
  localparam logic [SW-1:0] S_CHK   = 4'd2;
  localparam logic [SW-1:0] S_LAST  = 4'd3;
  localparam logic [SW-1:0] S_UP    = 4'd4;
  localparam logic [SW-1:0] S_UPC   = 4'd5;
  localparam logic [SW-1:0] S_DN    = 4'd6;
  localparam logic [SW-1:0] S_DNC   = 4'd7;
  localparam logic [SW-1:0] S_FIN   = 4'd8;
  localparam logic [SW-1:0] S_RDMIN = 4'd9;
  localparam logic [SW-1:0] S_OUT   = 4'd10;

  logic [SW-1:0]  state;
  logic [CW-1:0]  p;
  logic [CW-1:0]  size;
  logic [NHW-1:0] nh;
  logic [EW-1:0]  cur;
  logic           moved;
  logic           err;
  logic [HW-1:0]  given;
  logic [1:0]     op;
  logic [HW-1:0]  hreg;

  logic          hp_we;
  logic [CW-1:0] hp_waddr;
  logic [EW-1:0] hp_wdata;
  logic [CW-1:0] hp_ra, hp_rb;
  logic [EW-1:0] hp_da, hp_db;

  logic          hd_we;
  logic [HW-1:0] hd_waddr;
  logic [CW:0]   hd_wdata;
  logic [HW-1:0] hd_ra;
  logic [CW:0]   hd_da;

  ihp_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1), .AW(CW)) u_pos_ram (
    .clk     (clk),
    .we      (hp_we),
    .waddr   (hp_waddr),
    .wdata   (hp_wdata),
    .ra_addr (hp_ra),
    .ra_data (hp_da),
    .rb_addr (hp_rb),
    .rb_data (hp_db)
  );

  ihp_ram #(.WIDTH(CW + 1), .DEPTH(HANDLES + 1), .AW(HW)) u_hnd_ram (
    .clk     (clk),
    .we      (hd_we),
    .waddr   (hd_waddr),
    .wdata   (hd_wdata),
    .ra_addr (hd_ra),
    .ra_data (hd_da),
    .rb_addr (hd_ra),
    .rb_data ()
  );

  logic signed [VW-1:0] cur_v, a_v, b_v, rv, pick_v;
  logic [HW-1:0]        cur_h, a_h;
  logic [CW:0]          lpos, rpos;
  logic                 l_ok, r_ok, take_l, take_r, go_dn;
  logic [EW-1:0]        pick_e;
  logic [CW-1:0]        pick_p;
  logic                 hnd_ok;

  assign cur_v = cur[EW-1 -: VW];
  assign cur_h = cur[HW-1:0];
  assign a_v   = hp_da[EW-1 -: VW];
  assign a_h   = hp_da[HW-1:0];
  assign b_v   = hp_db[EW-1 -: VW];
  assign lpos  = {p, 1'b0};
  assign rpos  = {p, 1'b1};
  assign l_ok  = lpos <= {1'b0, size};
  assign r_ok  = rpos <= {1'b0, size};
  assign rv    = r_ok ? b_v : cur_v;
  assign take_l = a_v < rv;
  assign take_r = !take_l && r_ok;
  assign pick_e = take_l ? hp_da : hp_db;
  assign pick_v = pick_e[EW-1 -: VW];
  assign pick_p = take_l ? lpos[CW-1:0] : rpos[CW-1:0];
  assign go_dn  = l_ok && (take_l || take_r) && (pick_v < cur_v);
  assign hnd_ok = (handle != '0) && (NHW'(handle) < nh);
  assign busy   = state != S_IDLE;

  always_comb begin
    hp_ra = CW'(1);
    hp_rb = size;
    hd_ra = handle;
    unique case (state)
      S_UP:    hp_ra = p >> 1;
      S_DN: begin
        hp_ra = lpos[CW-1:0];
        hp_rb = rpos[CW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    hp_we    = 1'b0;
    hp_waddr = p;
    hp_wdata = cur;
    hd_we    = 1'b0;
    hd_waddr = cur_h;
    hd_wdata = {1'b1, p};
    unique case (state)
      S_IDLE: begin
        if (start && opcode == ihp_pkg::OP_INSERT && size < CW'(CAPACITY)
            && nh <= NHW'(HANDLES)) begin
          hd_we    = 1'b1;
          hd_waddr = nh[HW-1:0];
          hd_wdata = {1'b1, size + CW'(1)};
        end
      end
      S_RDM: begin
        hd_we    = 1'b1;
        hd_waddr = a_h;
        hd_wdata = '0;
      end
      S_CHK: begin
        if (hd_da[CW] && op == ihp_pkg::OP_DEL_HND) begin
          hd_we    = 1'b1;
          hd_waddr = hreg;
          hd_wdata = '0;
        end
      end
      S_UPC: begin
        if (cur_v < a_v) begin
          hp_we    = 1'b1;
          hp_wdata = hp_da;
          hd_we    = 1'b1;
          hd_waddr = a_h;
        end
      end
      S_DNC: begin
        if (go_dn) begin
          hp_we    = 1'b1;
          hp_wdata = pick_e;
          hd_we    = 1'b1;
          hd_waddr = pick_e[HW-1:0];
        end
      end
      S_FIN: begin
        hp_we = 1'b1;
        hd_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size  <= '0;
      nh    <= NHW'(1);
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= opcode;
            hreg  <= handle;
            err   <= 1'b0;
            given <= '0;
            moved <= 1'b0;
            unique case (opcode)
              ihp_pkg::OP_INSERT: begin
                if (size >= CW'(CAPACITY) || nh > NHW'(HANDLES)) begin
                  err   <= 1'b1;
                  state <= S_RDMIN;
                end else begin
                  cur   <= {value, nh[HW-1:0]};
                  p     <= size + CW'(1);
                  size  <= size + CW'(1);
                  given <= nh[HW-1:0];
                  nh    <= nh + NHW'(1);
                  state <= S_UP;
                end
              end
              ihp_pkg::OP_DEL_MIN: begin
                if (size == '0) begin
                  err   <= 1'b1;
                  state <= S_RDMIN;
                end else begin
                  state <= S_RDM;
                end
              end
              default: begin
                if (!hnd_ok) begin
                  err   <= 1'b1;
                  state <= S_RDMIN;
                end else begin
                  cur   <= {value, handle};
                  state <= S_CHK;
                end
              end
            endcase
          end
        end
        S_RDM: begin
          cur  <= hp_db;
          p    <= CW'(1);
          size <= size - CW'(1);
          state <= (size == CW'(1)) ? S_RDMIN : S_UP;
        end
        S_CHK: begin
          p <= hd_da[CW-1:0];
          if (!hd_da[CW]) begin
            err   <= 1'b1;
            state <= S_RDMIN;
          end else if (op == ihp_pkg::OP_DEL_HND) begin
            state <= S_LAST;
          end else begin
            state <= S_UP;
          end
        end
        S_LAST: begin
          cur  <= hp_db;
          size <= size - CW'(1);
          state <= (p == size) ? S_RDMIN : S_UP;
        end
        S_UP: begin
          if (p == CW'(1)) begin
            state <= moved ? S_FIN : S_DN;
          end else begin
            state <= S_UPC;
          end
        end
        S_UPC: begin
          if (cur_v < a_v) begin
            p     <= p >> 1;
            moved <= 1'b1;
            state <= S_UP;
          end else begin
            state <= moved ? S_FIN : S_DN;
          end
        end
        S_DN: state <= S_DNC;
        S_DNC: begin
          if (go_dn) begin
            p     <= pick_p;
            state <= S_DN;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN:   state <= S_RDMIN;
        S_RDMIN: state <= S_OUT;
        S_OUT: begin
          done        <= 1'b1;
          min_value   <= (size != '0) ? a_v : '0;
          heap_empty  <= size == '0;
          new_handle  <= given;
          error       <= err;
          entry_count <= size;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
